// ===== sv/hsjg_pkg.sv =====
// hsjg_pkg: shared widths, mode and register codes, reset values and the
// quarter-wave sine generator used to build the lookup table at elaboration
// no dependencies
package hsjg_pkg;

  // parameter defaults
  localparam int unsigned JOINTS_DEF          = 4;
  localparam int unsigned SINE_TABLE_BITS_DEF = 8;

  // field widths
  localparam int unsigned JOINT_W     = 2;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned MASK_W      = 4;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned TOL_W       = 15;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned LANE_W      = 16;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned MUL_W       = 17;
  localparam int unsigned PROD_W      = 2 * MUL_W;
  localparam int unsigned SINE_W      = 16;
  localparam int unsigned MAG_W       = 15;

  // stream packing
  localparam int unsigned IN_FIELDS_W  = JOINT_W + POS_W + 1 + PERIOD_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = JOINT_W + POS_W + MODE_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // run modes
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOMING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SINE   = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_MASK = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOMING_SPEED = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOME_TOL    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY   = 3'd4;

  // register reset values
  localparam logic [MASK_W-1:0]  TARGET_MASK_RST  = '0;
  localparam logic [SPEED_W-1:0] HOMING_SPEED_RST = 16'd410;
  localparam logic [TOL_W-1:0]   HOME_TOL_RST     = 15'd41;

  // quarter-wave polynomial coefficients, Q28
  localparam longint unsigned SIN_C1 = 64'd421657428;
  localparam longint unsigned SIN_C3 = 64'd173399665;
  localparam longint unsigned SIN_C5 = 64'd21392325;
  localparam longint unsigned SIN_C7 = 64'd1214632;

  // magnitude of the sine at quarter-wave step r (0 .. 2^qbits), Q14
  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned r,
                                                input int unsigned qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    x  = 64'(r) << (16 - qbits);
    x2 = (x * x) >> 16;
    p  = SIN_C7;
    p  = SIN_C5 - ((p * x2) >> 16);
    p  = SIN_C3 - ((p * x2) >> 16);
    p  = SIN_C1 - ((p * x2) >> 16);
    s  = (p * x) >> 16;
    s  = (s + 64'd8192) >> 14;
    if (s > 64'd16384) begin
      s = 64'd16384;
    end
    return MAG_W'(s);
  endfunction

endpackage

// ===== sv/hsjg_ram.sv =====
// hsjg_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module hsjg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/hsjg_sine_rom.sv =====
// hsjg_sine_rom: full-wave sine lookup from a quarter-wave constant table,
// signed Q14 result registered; depends on hsjg_pkg
module hsjg_sine_rom #(
  parameter int unsigned TABLE_BITS = hsjg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [TABLE_BITS-1:0]              idx_i,
  output logic signed [hsjg_pkg::SINE_W-1:0] sine_o
);
  import hsjg_pkg::*;

  localparam int unsigned QBITS   = TABLE_BITS - 2;
  localparam int unsigned QUARTER = 1 << QBITS;

  logic [MAG_W-1:0] quarter_tbl [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_tbl
    assign quarter_tbl[g] = sine_mag(g, QBITS);
  end

  logic [1:0]              quad;
  logic [QBITS:0]          step;
  logic signed [SINE_W-1:0] mag;
  logic signed [SINE_W-1:0] sine_q;

  always_comb begin
    quad = idx_i[TABLE_BITS-1 -: 2];
    step = {1'b0, idx_i[QBITS-1:0]};
    // odd quadrants run the quarter wave backwards
    if (quad[0]) begin
      step = {1'b1, {QBITS{1'b0}}} - step;
    end
    mag = SINE_W'(quarter_tbl[step]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q <= quad[1] ? -mag : mag;
    end
  end

  assign sine_o = sine_q;

endmodule

// ===== sv/hsjg_mul.sv =====
// hsjg_mul: shared signed 17x17 multiplier with registered product
// depends on hsjg_pkg
module hsjg_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [hsjg_pkg::MUL_W-1:0]  a_i,
  input  logic signed [hsjg_pkg::MUL_W-1:0]  b_i,
  output logic signed [hsjg_pkg::PROD_W-1:0] p_o
);
  import hsjg_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/homing_then_sine_joint_generator_core.sv =====
// homing_then_sine_joint_generator_core: top level, sequencer, mode logic
// and configuration registers; depends on hsjg_pkg, hsjg_ram, hsjg_mul,
// hsjg_sine_rom
//
// Each joint sample is taken in one request and produces at most one command.
// An item runs from acceptance and phase memory read through the first multiply
// (homing speed or sine frequency by the tick period), the phase update with
// write-back and sine table read, and the second multiply (amplitude by sine)
// to output; the block is then ready again, but output holds while a command
// has nowhere to go. One 17x17 multiplier is shared by both products and the
// per-joint phases live in a small RAM with registered read data. An output
// register holds a finished command so the next sample can be taken while it
// waits. The phase RAM has a valid bit per joint, cleared by reset and on
// entry to sine mode, so no clearing pass is needed after reset. Mode changes
// commit on the sample flagged tlast; configuration must be written while idle.
module homing_then_sine_joint_generator_core #(
  parameter int unsigned JOINTS          = hsjg_pkg::JOINTS_DEF,
  parameter int unsigned SINE_TABLE_BITS = hsjg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // joint_index[1:0], position[17:2], enable[18], period[34:19], zero fill
  input  logic [hsjg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tlast,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // command_joint[1:0], command_position[17:2], mode_now[19:18], zero fill
  output logic [hsjg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [hsjg_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [hsjg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import hsjg_pkg::*;

  localparam int unsigned AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_PHASE = 3'd2;
  localparam logic [2:0] ST_AMP   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  function automatic logic signed [POS_W-1:0] sat16(input logic signed [POS_W+1:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[POS_W-1:0];
  endfunction

  // configuration registers
  logic [MASK_W-1:0]  mask_q;
  logic [SPEED_W-1:0] speed_q;
  logic [TOL_W-1:0]   tol_q;
  logic [WORD_W-1:0]  amp_words_q;
  logic [WORD_W-1:0]  freq_words_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= TARGET_MASK_RST;
      speed_q      <= HOMING_SPEED_RST;
      tol_q        <= HOME_TOL_RST;
      amp_words_q  <= '0;
      freq_words_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET_MASK:  mask_q       <= cfg_data_i[MASK_W-1:0];
        REG_HOMING_SPEED: speed_q      <= cfg_data_i[SPEED_W-1:0];
        REG_HOME_TOL:     tol_q        <= cfg_data_i[TOL_W-1:0];
        REG_AMPLITUDE:    amp_words_q  <= cfg_data_i[WORD_W-1:0];
        REG_FREQUENCY:    freq_words_q <= cfg_data_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]        state_q, state_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic              homed_q, homed_d;
  logic [JOINTS-1:0] vld_q, vld_d;
  logic              out_valid_q, out_valid_d;

  // item payload
  logic [JOINT_W-1:0]      joint_q;
  logic signed [POS_W-1:0] pos_q;
  logic                    en_q;
  logic [PERIOD_W-1:0]     period_q;
  logic                    last_q;

  // result payload
  logic [JOINT_W-1:0]      out_joint_q;
  logic signed [POS_W-1:0] out_pos_q;
  logic [MODE_W-1:0]       out_mode_q;

  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [AW-1:0] phase_addr;
  logic          driven;
  assign phase_addr = joint_q[AW-1:0];
  assign driven     = ({1'b0, joint_q} < (JOINT_W + 1)'(JOINTS)) && mask_q[joint_q];

  logic [LANE_W-1:0] freq_lane;
  logic [LANE_W-1:0] amp_lane;
  assign freq_lane = freq_words_q[LANE_W*joint_q +: LANE_W];
  assign amp_lane  = amp_words_q[LANE_W*joint_q +: LANE_W];

  // shared multiplier
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [SINE_W-1:0] sine;

  always_comb begin
    mul_en = (state_q == ST_MUL) || ((state_q == ST_AMP) && (mode_q == MODE_SINE));
    if (state_q == ST_AMP) begin
      mul_a = {amp_lane[LANE_W-1], amp_lane};
      mul_b = {sine[SINE_W-1], sine};
    end else begin
      mul_a = {1'b0, (mode_q == MODE_HOMING) ? speed_q : freq_lane};
      mul_b = {1'b0, period_q};
    end
  end

  hsjg_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // phase memory: read at accept, read-modify-write in ST_PHASE; one item
  // at a time so reads and write-backs never overlap
  logic [PHASE_W-1:0] ram_rdata;
  logic [PHASE_W-1:0] phase_old, phase_new;
  logic               phase_we;

  always_comb begin
    phase_old = vld_q[phase_addr] ? ram_rdata : '0;
    phase_new = phase_old + {prod[PHASE_W-5:0], 4'b0000};
    phase_we  = (state_q == ST_PHASE) && (mode_q == MODE_SINE) && en_q && driven;
  end

  hsjg_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (JOINTS)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (phase_we),
    .waddr_i (phase_addr),
    .wdata_i (phase_new),
    .re_i    (accept),
    .raddr_i (s_axis_tdata[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  hsjg_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .en_i   (state_q == ST_PHASE),
    .idx_i  (phase_new[PHASE_W-1 -: SINE_TABLE_BITS]),
    .sine_o (sine)
  );

  // result arithmetic
  logic signed [POS_W:0]   pos_mag;
  logic [PHASE_W:0]        step_sum;
  logic signed [POS_W+1:0] pos_x, step_x, home_cmd;
  logic [PHASE_W-1:0]      sine_round;
  logic                    home_emit, sine_emit, emit, out_load;
  logic signed [POS_W-1:0] cmd;

  always_comb begin
    pos_mag    = pos_q[POS_W-1] ? -{pos_q[POS_W-1], pos_q} : {pos_q[POS_W-1], pos_q};
    step_sum   = {1'b0, prod[PHASE_W-1:0]} + (PHASE_W + 1)'(1 << 19);
    pos_x      = {{2{pos_q[POS_W-1]}}, pos_q};
    step_x     = {5'b0, step_sum[PHASE_W:20]};
    home_cmd   = (pos_q > 16'sd0) ? pos_x - step_x : pos_x + step_x;
    sine_round = prod[PHASE_W-1:0] + 32'd8192;
    home_emit  = (mode_q == MODE_HOMING) && driven && (pos_mag > $signed({2'b00, tol_q}));
    sine_emit  = (mode_q == MODE_SINE) && en_q && driven;
    emit       = home_emit || sine_emit;
    cmd        = home_emit ? sat16(home_cmd) : sat16($signed(sine_round[PHASE_W-1:14]));
    out_load   = (state_q == ST_OUT) && emit && (!out_valid_q || m_axis_tready);
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    homed_d     = homed_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (phase_we) begin
      vld_d[phase_addr] = 1'b1;
    end
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MUL;
      ST_MUL:   state_d = ST_PHASE;
      ST_PHASE: state_d = ST_AMP;
      ST_AMP:   state_d = ST_OUT;
      ST_OUT: begin
        // hold here while a command has nowhere to go
        if (!emit || out_load) begin
          state_d = ST_IDLE;
          if (out_load) begin
            out_valid_d = 1'b1;
          end
          if (home_emit) begin
            homed_d = 1'b0;
          end
          if (last_q) begin
            homed_d = 1'b1;
            case (mode_q)
              MODE_HOMING: begin
                if (homed_q && !home_emit) begin
                  mode_d = MODE_SINE;
                  vld_d  = '0;
                end
              end
              MODE_SINE: if (!en_q) mode_d = MODE_IDLE;
              default:   if (en_q) mode_d = MODE_HOMING;
            endcase
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_IDLE;
      homed_q     <= 1'b1;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      homed_q     <= homed_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      joint_q  <= s_axis_tdata[JOINT_W-1:0];
      pos_q    <= s_axis_tdata[JOINT_W +: POS_W];
      en_q     <= s_axis_tdata[JOINT_W+POS_W];
      period_q <= s_axis_tdata[JOINT_W+POS_W+1 +: PERIOD_W];
      last_q   <= s_axis_tlast;
    end
    if (out_load) begin
      out_joint_q <= joint_q;
      out_pos_q   <= cmd;
      out_mode_q  <= mode_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_mode_q, out_pos_q, out_joint_q};

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for homing_then_sine_joint_generator_core
// a class predicts the command for each accepted joint sample and checks the output stream
// depends on hsjg_pkg and the core rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hsjg_pkg::*;

  localparam int unsigned TABLE_BITS    = 8;
  localparam int unsigned QUARTER_BITS  = TABLE_BITS - 2;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 48;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SHOWN_ERRORS  = 10;

  // quarter-wave sine polynomial, Q28
  localparam longint unsigned POLY_C1 = 64'd421657428;
  localparam longint unsigned POLY_C3 = 64'd173399665;
  localparam longint unsigned POLY_C5 = 64'd21392325;
  localparam longint unsigned POLY_C7 = 64'd1214632;

  typedef struct packed {
    bit [1:0]  joint;
    bit [15:0] pos;
    bit [1:0]  mode;
  } command_t;

  class joint_command_model;
    bit [3:0]    mask;
    bit [15:0]   speed;
    bit [14:0]   tol;
    bit [63:0]   amps;
    bit [63:0]   freqs;
    bit [1:0]    mode;
    bit [31:0]   phase [4];
    bit          homed;
    command_t    expected_cmds [$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned mode_cmds [3];

    function new();
      mask      = 4'h0;
      speed     = 16'd410;
      tol       = 15'd41;
      amps      = '0;
      freqs     = '0;
      mode      = MODE_IDLE;
      phase     = '{default: '0};
      homed     = 1'b1;
      n_errors  = 0;
      n_checked = 0;
      mode_cmds = '{default: 0};
    endfunction

    function void set_reg(bit [CFG_INDEX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TARGET_MASK:  mask  = val[3:0];
        REG_HOMING_SPEED: speed = val[15:0];
        REG_HOME_TOL:     tol   = val[14:0];
        REG_AMPLITUDE:    amps  = val;
        REG_FREQUENCY:    freqs = val;
        default: ;
      endcase
    endfunction

    function bit [15:0] clamp16(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return 16'(v);
    endfunction

    // signed Q14 sine for a table index, mirrored from one quarter wave
    function int sine_at(bit [TABLE_BITS-1:0] idx);
      bit [1:0] quad;
      longint unsigned r, x, x2, p, s;
      quad = idx[TABLE_BITS-1 -: 2];
      r    = idx[QUARTER_BITS-1:0];
      if (quad[0]) r = (64'd1 << QUARTER_BITS) - r;
      x  = r << (16 - QUARTER_BITS);
      x2 = (x * x) >> 16;
      p  = POLY_C7;
      p  = POLY_C5 - ((p * x2) >> 16);
      p  = POLY_C3 - ((p * x2) >> 16);
      p  = POLY_C1 - ((p * x2) >> 16);
      s  = (p * x) >> 16;
      s  = (s + 64'd8192) >> 14;
      if (s > 64'd16384) s = 64'd16384;
      return quad[1] ? -int'(s) : int'(s);
    endfunction

    function void note_sample(bit [1:0] j, bit [15:0] pos_bits, bit en, bit [15:0] per,
                              bit last);
      command_t  c;
      bit        emit;
      longint    pos, step, amp, num;
      bit [31:0] inc;
      int        sv;
      pos    = longint'($signed(pos_bits));
      emit   = 1'b0;
      c.joint = j;
      c.mode  = mode;
      c.pos   = '0;
      case (mode)
        MODE_HOMING: begin
          if (mask[j] && ((pos < 0) ? -pos : pos) > longint'(tol)) begin
            step  = longint'((64'(speed) * 64'(per) + 64'd524288) >> 20);
            c.pos = clamp16((pos > 0) ? pos - step : pos + step);
            homed = 1'b0;
            emit  = 1'b1;
          end
          if (last && homed) begin
            phase = '{default: '0};
            mode  = MODE_SINE;
          end
        end
        MODE_SINE: begin
          if (!en) begin
            if (last) mode = MODE_IDLE;
          end else if (mask[j]) begin
            inc      = (32'(freqs[16*j +: 16]) * 32'(per)) << 4;
            phase[j] = phase[j] + inc;
            sv       = sine_at(phase[j][31 -: TABLE_BITS]);
            amp      = longint'($signed(amps[16*j +: 16]));
            num      = amp * longint'(sv) + 64'sd8192;
            c.pos    = clamp16(num >>> 14);
            emit     = 1'b1;
          end
        end
        default: begin
          if (last && en) mode = MODE_HOMING;
        end
      endcase
      if (last) homed = 1'b1;
      if (emit) expected_cmds = {expected_cmds, c};
    endfunction

    function void check_command(logic [OUT_TDATA_W-1:0] d);
      command_t e;
      n_checked++;
      if (expected_cmds.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOWN_ERRORS) begin
          $display("unexpected command: joint %0d position %0d mode %0d",
                   d[1:0], $signed(d[17:2]), d[19:18]);
        end
        return;
      end
      e = expected_cmds.pop_front();
      if (d[1:0] !== e.joint || d[17:2] !== e.pos || d[19:18] !== e.mode) begin
        n_errors++;
        if (n_errors <= SHOWN_ERRORS) begin
          $display("command mismatch: expected joint %0d position %0d mode %0d",
                   e.joint, $signed(e.pos), e.mode);
          $display("                  got      joint %0d position %0d mode %0d",
                   d[1:0], $signed(d[17:2]), d[19:18]);
        end
      end else begin
        mode_cmds[e.mode]++;
      end
    endfunction

    function void flag_leftovers();
      if (expected_cmds.size() != 0) begin
        n_errors += expected_cmds.size();
        $display("%0d expected commands never arrived", expected_cmds.size());
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  joint_command_model cmds = new();
  bit          steady      = 1'b0;
  int unsigned sink_hold   = 0;
  int unsigned n_items     = 0;
  int unsigned n_settings  = 0;
  int unsigned idle_cycles = 0;

  homing_then_sine_joint_generator_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // command sink: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) cmds.check_command(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit [15:0] pick_period();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2, 3, 4: return 16'($urandom_range(4096));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit [15:0] pick_position();
    case ($urandom_range(19))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic cfg_write(input bit [CFG_INDEX_W-1:0] idx, input bit [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cmds.set_reg(idx, val);
  endtask

  task automatic send_sample(input bit [1:0] j, input bit [15:0] pos, input bit en,
                             input bit [15:0] per, input bit last);
    while (!steady && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= IN_TDATA_W'({per, en, pos, j});
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cmds.note_sample(j, pos, en, per, last);
    n_items++;
  endtask

  // stop offering and wait for every predicted command, then let the pipe empty
  task automatic drain(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    while (cmds.expected_cmds.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic load_random_settings(input bit all_driven, input bit far_end);
    bit [63:0] junk;
    bit [3:0]  mask_v;
    bit [15:0] speed_v;
    bit [14:0] tol_v;
    bit [63:0] amp_v;
    bit [63:0] freq_v;
    junk   = {$urandom, $urandom};
    mask_v = ($urandom_range(99) < 20) ? 4'hf : 4'($urandom_range(15));
    if (all_driven) mask_v = 4'hf;
    case ($urandom_range(4))
      0:       speed_v = 16'h0000;
      1:       speed_v = 16'hffff;
      default: speed_v = 16'($urandom);
    endcase
    case ($urandom_range(5))
      0:       tol_v = 15'h0000;
      1:       tol_v = 15'h7fff;
      default: tol_v = 15'($urandom_range(3000));
    endcase
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(5))
        0:       amp_v[16*i +: 16] = 16'h7fff;
        1:       amp_v[16*i +: 16] = 16'h8000;
        2:       amp_v[16*i +: 16] = 16'h0000;
        default: amp_v[16*i +: 16] = 16'($urandom);
      endcase
      case ($urandom_range(5))
        0:       freq_v[16*i +: 16] = 16'hffff;
        1:       freq_v[16*i +: 16] = 16'h0000;
        2, 3:    freq_v[16*i +: 16] = 16'($urandom_range(1023));
        default: freq_v[16*i +: 16] = 16'($urandom);
      endcase
    end
    if (far_end) begin
      speed_v = 16'h0000;
      tol_v   = 15'h7fff;
    end
    // upper bits of the narrow registers carry junk that must be dropped
    cfg_write(REG_TARGET_MASK, {junk[63:4], mask_v});
    cfg_write(REG_HOMING_SPEED, {junk[63:16], speed_v});
    cfg_write(REG_HOME_TOL, {junk[63:15], tol_v});
    cfg_write(REG_AMPLITUDE, amp_v);
    cfg_write(REG_FREQUENCY, freq_v);
    // index past the last register, must be ignored
    cfg_write(REG_FREQUENCY + 3'($urandom_range(1, 3)), {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // one control tick: mostly joints 0..3 in order, sometimes a ragged tick
  task automatic run_tick();
    int unsigned count;
    bit          noisy, settle, last, en;
    bit [1:0]    j;
    bit [15:0]   pos, per;
    noisy  = $urandom_range(99) < 12;
    count  = noisy ? $urandom_range(1, 6) : 4;
    settle = (cmds.mode == MODE_HOMING) && ($urandom_range(99) < 45);
    per    = pick_period();
    for (int k = 0; k < count; k++) begin
      last = (k == count - 1);
      j    = noisy ? 2'($urandom_range(3)) : 2'(k);
      if (settle) begin
        pos = 16'(int'($urandom_range(2 * cmds.tol)) - int'(cmds.tol));
      end else begin
        pos = pick_position();
      end
      if (cmds.mode == MODE_SINE) begin
        en = last ? ($urandom_range(99) >= 15) : ($urandom_range(99) < 90);
      end else if (cmds.mode == MODE_IDLE && last) begin
        en = $urandom_range(99) < 70;
      end else begin
        en = 1'($urandom);
      end
      if ($urandom_range(99) < 10) per = pick_period();
      send_sample(j, pos, en, per, last);
    end
  endtask

  // a homed tick moves homing to sine, a disabled tick moves sine to idle
  task automatic bring_to_idle();
    while (cmds.mode != MODE_IDLE) send_sample(2'd0, 16'h0000, 1'b0, pick_period(), 1'b1);
  endtask

  initial begin
    int unsigned start;
    bit          paused;
    paused = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of speed, tolerance, amplitudes and frequencies
    cfg_write(REG_TARGET_MASK, 64'hf);
    cfg_we_i <= 1'b0;
    n_settings++;
    send_sample(2'd0, 16'h0000, 1'b1, 16'd1000, 1'b1);
    send_sample(2'd0, 16'd100, 1'b0, 16'hffff, 1'b0);
    send_sample(2'd1, 16'(-100), 1'b0, 16'hffff, 1'b0);
    send_sample(2'd2, 16'd41, 1'b0, 16'hffff, 1'b0);
    send_sample(2'd3, 16'(-42), 1'b1, 16'hffff, 1'b1);
    send_sample(2'd0, 16'h0000, 1'b0, 16'hffff, 1'b1);
    send_sample(2'd1, 16'h7fff, 1'b1, 16'hffff, 1'b0);
    send_sample(2'd2, 16'h1234, 1'b1, 16'd300, 1'b0);
    send_sample(2'd3, 16'h0000, 1'b0, 16'h0000, 1'b1);

    // largest step, zero tolerance, sine landing on the positive and negative peaks
    drain(SETTLE_CYCLES);
    cfg_write(REG_TARGET_MASK, 64'hf);
    cfg_write(REG_HOMING_SPEED, 64'hffff);
    cfg_write(REG_HOME_TOL, 64'h0);
    cfg_write(REG_AMPLITUDE, {16'hffff, 16'h0001, 16'h8000, 16'h7fff});
    cfg_write(REG_FREQUENCY, {16'h0000, 16'hffff, 16'h1800, 16'h0800});
    cfg_write(REG_FREQUENCY + 3'd3, 64'hffff_ffff_ffff_ffff);
    cfg_we_i <= 1'b0;
    n_settings++;
    send_sample(2'd1, 16'h0000, 1'b1, 16'h0000, 1'b1);
    send_sample(2'd0, 16'h7fff, 1'b0, 16'hffff, 1'b0);
    send_sample(2'd1, 16'h8000, 1'b1, 16'hffff, 1'b0);
    send_sample(2'd2, 16'h0000, 1'b0, 16'hffff, 1'b0);
    send_sample(2'd3, 16'h0001, 1'b1, 16'h0000, 1'b1);
    send_sample(2'd2, 16'h0000, 1'b0, 16'h0000, 1'b1);
    send_sample(2'd0, 16'h5555, 1'b1, 16'h8000, 1'b0);
    send_sample(2'd1, 16'haaaa, 1'b1, 16'h8000, 1'b0);
    send_sample(2'd2, 16'h0f0f, 1'b1, 16'h8000, 1'b0);
    send_sample(2'd3, 16'hf0f0, 1'b1, 16'h8000, 1'b0);
    send_sample(2'd0, 16'h0000, 1'b0, 16'h1234, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      drain(SETTLE_CYCLES);
      load_random_settings(p == 3, p == 6);
      steady = (p == 2);
      if (p == 3) sink_hold = HOLD_CYCLES;
      start  = n_items;
      paused = 1'b0;
      while (n_items - start < PHASE_ITEMS) begin
        run_tick();
        if (p == 5 && !paused && n_items - start >= PHASE_ITEMS / 2) begin
          drain(0);
          paused = 1'b1;
        end
      end
      steady = 1'b0;
      bring_to_idle();
    end

    drain(SETTLE_CYCLES);
    cmds.flag_leftovers();
    $display("sent %0d joint samples under %0d register settings, %0d commands received",
             n_items, n_settings, cmds.n_checked);
    $display("matching commands: homing %0d, sine %0d; failures %0d",
             cmds.mode_cmds[MODE_HOMING], cmds.mode_cmds[MODE_SINE], cmds.n_errors);
    if (cmds.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
